/* design/shsc_pkg.sv */
`default_nettype none

package shsc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_ENABLE          = 3'd0;
    localparam logic [2:0] REG_RUN_MODE        = 3'd1;
    localparam logic [2:0] REG_TARGET_TEMP     = 3'd2;
    localparam logic [2:0] REG_TARGET_HUMIDITY = 3'd3;
    localparam logic [2:0] REG_TEMP_BAND       = 3'd4;
    localparam logic [2:0] REG_FAN_DELTA       = 3'd5;
    localparam logic [2:0] REG_FAN_REQUEST     = 3'd6;

    // Run modes. The fourth code is treated as dry heat.
    localparam logic [1:0] MODE_DRY    = 2'd0;
    localparam logic [1:0] MODE_BIO    = 2'd1;
    localparam logic [1:0] MODE_CUSTOM = 2'd2;

    localparam logic [6:0] TEMP_BAND_RESET = 7'd20;
    localparam logic [6:0] FAN_DELTA_RESET = 7'd20;

    localparam int unsigned ENERGY_W = 48;

    typedef struct packed {
        logic       enable;
        logic [1:0] run_mode;
        logic [6:0] target_temp;
        logic [6:0] target_humidity;
        logic [6:0] temp_band;
        logic [6:0] fan_delta;
        logic       fan_request;
    } cfg_t;

    typedef struct packed {
        logic [1:0] heat_stages;
        logic       steam_on;
        logic       fan_on;
    } drive_t;

endpackage

`default_nettype wire

/* design/shsc_cfg.sv */
`default_nettype none

module shsc_cfg
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [2:0]    wr_index,
    input  wire logic [6:0]    wr_data,
    output shsc_pkg::cfg_t     cfg
);

    shsc_pkg::cfg_t cfg_reg;
    shsc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                shsc_pkg::REG_ENABLE:          cfg_next.enable          = wr_data[0];
                shsc_pkg::REG_RUN_MODE:        cfg_next.run_mode        = wr_data[1:0];
                shsc_pkg::REG_TARGET_TEMP:     cfg_next.target_temp     = wr_data;
                shsc_pkg::REG_TARGET_HUMIDITY: cfg_next.target_humidity = wr_data;
                shsc_pkg::REG_TEMP_BAND:       cfg_next.temp_band       = wr_data;
                shsc_pkg::REG_FAN_DELTA:       cfg_next.fan_delta       = wr_data;
                shsc_pkg::REG_FAN_REQUEST:     cfg_next.fan_request     = wr_data[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable          <= 1'b0;
            cfg_reg.run_mode        <= shsc_pkg::MODE_DRY;
            cfg_reg.target_temp     <= 7'd0;
            cfg_reg.target_humidity <= 7'd0;
            cfg_reg.temp_band       <= shsc_pkg::TEMP_BAND_RESET;
            cfg_reg.fan_delta       <= shsc_pkg::FAN_DELTA_RESET;
            cfg_reg.fan_request     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* design/shsc_ctrl.sv */
`default_nettype none

module shsc_ctrl
(
    input  wire shsc_pkg::cfg_t       cfg,
    input  wire logic signed [14:0]   top_temp,
    input  wire logic signed [14:0]   bottom_temp,
    input  wire logic [13:0]          top_humidity,
    output shsc_pkg::drive_t          drive
);

    logic signed [17:0] top_s;
    logic signed [17:0] bottom_s;
    logic signed [17:0] diff;
    logic signed [17:0] fan_lim;
    logic signed [17:0] tgt;
    logic signed [17:0] band_lim;
    logic signed [17:0] tgt_lo;
    logic signed [17:0] gap;
    logic signed [17:0] third_lim;
    logic [12:0]        band_x43;
    logic [5:0]         band_third;
    logic [13:0]        hum_lim;
    logic               humid_mode;
    logic [1:0]         stages;

    assign top_s    = 18'(top_temp);
    assign bottom_s = 18'(bottom_temp);
    assign diff     = top_s - bottom_s;
    assign fan_lim  = signed'(18'(cfg.fan_delta)) * 18'sd100;

    // floor(band / 3) for a 7-bit band, as a multiply by 43/128.
    assign band_x43   = 13'(cfg.temp_band) * 13'd43;
    assign band_third = band_x43[12:7];
    assign third_lim  = signed'(18'(band_third)) * 18'sd100;

    // Bio mode heats to 100 minus the humidity target, which may go negative.
    assign tgt = (cfg.run_mode == shsc_pkg::MODE_BIO)
               ? (18'sd100 - signed'(18'(cfg.target_humidity))) * 18'sd100
               : signed'(18'(cfg.target_temp)) * 18'sd100;

    assign band_lim = signed'(18'(cfg.temp_band)) * 18'sd100;
    assign tgt_lo   = tgt - band_lim;
    assign gap      = tgt - top_s;

    assign hum_lim    = 14'(cfg.target_humidity) * 14'd100;
    assign humid_mode = (cfg.run_mode == shsc_pkg::MODE_BIO)
                     || (cfg.run_mode == shsc_pkg::MODE_CUSTOM);

    always_comb
    begin
        if (top_s > tgt)
        begin
            stages = 2'd0;
        end
        else if ((top_s > tgt_lo) && (gap < third_lim))
        begin
            stages = 2'd2;
        end
        else
        begin
            stages = 2'd3;
        end
    end

    always_comb
    begin
        drive = '0;
        if (cfg.enable)
        begin
            drive.heat_stages = stages;
            drive.steam_on    = humid_mode && (top_humidity <= hum_lim);
            drive.fan_on      = (diff > fan_lim) && cfg.fan_request;
        end
    end

endmodule

`default_nettype wire

/* design/shsc_energy.sv */
`default_nettype none

module shsc_energy
#(
    parameter int unsigned FLUSH_INTERVAL_MS = 10000
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic                          enable,
    input  wire logic [31:0]                   now_ms,
    input  wire shsc_pkg::drive_t              drive,
    output logic [shsc_pkg::ENERGY_W-1:0]      total_energy,
    output logic [shsc_pkg::ENERGY_W-1:0]      session_energy
);

    localparam int unsigned EW = shsc_pkg::ENERGY_W;

    logic          fresh_reg;
    logic          fresh_next;
    logic [31:0]   last_flush_reg;
    logic [31:0]   last_flush_next;
    logic [2:0]    load_now_reg;
    logic [2:0]    load_now_next;
    logic [2:0]    load_before_reg;
    logic [2:0]    load_before_next;
    logic [EW-1:0] lifetime_reg;
    logic [EW-1:0] lifetime_next;
    logic [EW-1:0] session_reg;
    logic [EW-1:0] session_next;

    logic [31:0]   last_eff;
    logic [31:0]   elapsed;
    logic          flush;
    logic          add_en;
    logic [2:0]    mul_load;
    logic [34:0]   product;
    logic [EW:0]   life_sum;
    logic [EW:0]   sess_sum;
    logic [EW-1:0] life_sat;
    logic [EW-1:0] sess_sat;
    logic [2:0]    load_tick;

    // A fresh start measures from this tick.
    assign last_eff = fresh_reg ? now_ms : last_flush_reg;
    assign elapsed  = now_ms - last_eff;
    assign flush    = ((load_now_reg != 3'd0) && (elapsed > 32'(FLUSH_INTERVAL_MS)))
                   || (load_before_reg != load_now_reg);

    // Running ticks bill the load of two ticks back; switching off bills the last load.
    assign mul_load = enable ? load_before_reg : load_now_reg;
    assign add_en   = enable ? flush : (!fresh_reg && (load_now_reg != 3'd0));

    assign product = (mul_load[0] ? 35'(elapsed)          : 35'd0)
                   + (mul_load[1] ? 35'({elapsed, 1'b0})  : 35'd0)
                   + (mul_load[2] ? 35'({elapsed, 2'b00}) : 35'd0);

    assign life_sum = (EW+1)'(lifetime_reg) + (EW+1)'(product);
    assign sess_sum = (EW+1)'(session_reg) + (EW+1)'(product);
    assign life_sat = life_sum[EW] ? '1 : life_sum[EW-1:0];
    assign sess_sat = sess_sum[EW] ? '1 : sess_sum[EW-1:0];

    assign load_tick = 3'(drive.heat_stages) + 3'(drive.steam_on);

    always_comb
    begin
        fresh_next       = fresh_reg;
        last_flush_next  = last_flush_reg;
        load_now_next    = load_now_reg;
        load_before_next = load_before_reg;
        lifetime_next    = lifetime_reg;
        session_next     = session_reg;
        if (step)
        begin
            if (enable)
            begin
                fresh_next       = 1'b0;
                last_flush_next  = flush ? now_ms : last_eff;
                load_before_next = load_now_reg;
                load_now_next    = load_tick;
                if (add_en)
                begin
                    lifetime_next = life_sat;
                    session_next  = sess_sat;
                end
            end
            else
            begin
                fresh_next      = 1'b1;
                last_flush_next = 32'd0;
                load_now_next   = 3'd0;
                session_next    = '0;
                if (add_en)
                begin
                    lifetime_next = life_sat;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg       <= 1'b1;
            last_flush_reg  <= 32'd0;
            load_now_reg    <= 3'd0;
            load_before_reg <= 3'd0;
            lifetime_reg    <= '0;
            session_reg     <= '0;
        end
        else
        begin
            fresh_reg       <= fresh_next;
            last_flush_reg  <= last_flush_next;
            load_now_reg    <= load_now_next;
            load_before_reg <= load_before_next;
            lifetime_reg    <= lifetime_next;
            session_reg     <= session_next;
        end
    end

    // The totals only change together with a result, so they are read out directly.
    assign total_energy   = lifetime_reg;
    assign session_energy = session_reg;

    a_session_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !enable) |=> (session_reg == '0) && fresh_reg && (load_now_reg == 3'd0))
        else $error("session state not cleared after a disabled tick");

    a_lifetime_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (lifetime_reg >= $past(lifetime_reg)))
        else $error("lifetime energy decreased");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(lifetime_reg) && $stable(session_reg) && $stable(load_now_reg))
        else $error("energy state changed without a tick");

    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        (load_now_reg <= 3'd4) && (load_before_reg <= 3'd4))
        else $error("load out of range");

endmodule

`default_nettype wire

/* design/staged_heater_steam_controller.sv */
// Staged heater, steam and turbo-fan controller with energy metering.
//
// Ticks enter on the s_axis channel (time and sensor readings) and one result
// per tick leaves on the m_axis channel: heater stages, steam and fan drives and
// the lifetime and session energy totals in stage-milliseconds. Registers are
// written over the cfg channel, which is always ready; write it only while no
// transaction is in flight.
//
// A tick is captured in an input register and then resolved into the output
// register; while the receiver takes results, the block takes one tick per
// cycle. The energy state is updated in the same cycle that the result
// register loads.
// When the receiver stalls, the result is held and one further tick waits in
// the input register; s_axis_tready then drops until the result is taken.
// Reset empties both registers, restores the default registers (disabled, band
// and fan delta of 20 degrees) and clears all energy totals.
`default_nettype none

module staged_heater_steam_controller
#(
    parameter int unsigned FLUSH_INTERVAL_MS = 10000
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,

    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // now_ms[31:0], top_temp[46:32], bottom_temp[61:47], top_humidity[75:62]
    input  wire logic [79:0]   s_axis_tdata,

    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // heat_stages[1:0], steam_on[2], fan_on[3], total_energy[51:4],
    // session_energy[99:52]
    output logic [103:0]       m_axis_tdata,

    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [6:0]    cfg_data
);

    shsc_pkg::cfg_t   cfg;
    shsc_pkg::drive_t drive;

    logic                                 in_valid_reg;
    logic                                 in_valid_next;
    logic [31:0]                          in_now_reg;
    logic signed [14:0]                   in_top_reg;
    logic signed [14:0]                   in_bottom_reg;
    logic [13:0]                          in_hum_reg;

    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    shsc_pkg::drive_t                     out_drive_reg;

    logic [shsc_pkg::ENERGY_W-1:0]        total_energy;
    logic [shsc_pkg::ENERGY_W-1:0]        session_energy;

    logic                                 in_accept;
    logic                                 advance;

    assign cfg_ready = 1'b1;

    shsc_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_now_reg    <= s_axis_tdata[31:0];
            in_top_reg    <= s_axis_tdata[46:32];
            in_bottom_reg <= s_axis_tdata[61:47];
            in_hum_reg    <= s_axis_tdata[75:62];
        end
        if (advance)
        begin
            out_drive_reg <= drive;
        end
    end

    shsc_ctrl u_ctrl
    (
        .cfg          (cfg),
        .top_temp     (in_top_reg),
        .bottom_temp  (in_bottom_reg),
        .top_humidity (in_hum_reg),
        .drive        (drive)
    );

    shsc_energy
    #(
        .FLUSH_INTERVAL_MS (FLUSH_INTERVAL_MS)
    )
    u_energy
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .enable         (cfg.enable),
        .now_ms         (in_now_reg),
        .drive          (drive),
        .total_energy   (total_energy),
        .session_energy (session_energy)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, session_energy, total_energy,
                            out_drive_reg.fan_on, out_drive_reg.steam_on,
                            out_drive_reg.heat_stages};

endmodule

`default_nettype wire

/* tb/sv/staged_heater_steam_controller_tb.sv */
`timescale 1ns / 100ps

module staged_heater_steam_controller_tb;

    localparam int unsigned FLUSH_MS = 10000;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_TICKS = 520;
    localparam int WRAP_TICKS = 32;

    typedef struct {
        shsc_pkg::drive_t drive;
        logic [47:0]      total;
        logic [47:0]      session;
    } tick_result_t;

    // Mirrors the controller: register file, energy meter state and the
    // queue of results still owed by the block.
    class heater_scoreboard;
        shsc_pkg::cfg_t regs;
        bit             fresh;
        logic [31:0]    flush_stamp;
        logic [2:0]     load_last;
        logic [2:0]     load_prior;
        logic [47:0]    lifetime_sm;
        logic [47:0]    session_sm;
        tick_result_t   pending_q[$];
        int             fail_count;

        function new();
            regs = '0;
            regs.temp_band = shsc_pkg::TEMP_BAND_RESET;
            regs.fan_delta = shsc_pkg::FAN_DELTA_RESET;
            fresh = 1'b1;
            flush_stamp = '0;
            load_last = '0;
            load_prior = '0;
            lifetime_sm = '0;
            session_sm = '0;
            fail_count = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [6:0] val);
            case (idx)
                shsc_pkg::REG_ENABLE:          regs.enable = val[0];
                shsc_pkg::REG_RUN_MODE:        regs.run_mode = val[1:0];
                shsc_pkg::REG_TARGET_TEMP:     regs.target_temp = val;
                shsc_pkg::REG_TARGET_HUMIDITY: regs.target_humidity = val;
                shsc_pkg::REG_TEMP_BAND:       regs.temp_band = val;
                shsc_pkg::REG_FAN_DELTA:       regs.fan_delta = val;
                shsc_pkg::REG_FAN_REQUEST:     regs.fan_request = val[0];
                default: ;
            endcase
        endfunction

        static function logic [47:0] sat_add(logic [47:0] acc, logic [63:0] amount);
            logic [63:0] sum;
            sum = {16'd0, acc} + amount;
            return (sum > 64'h0000_FFFF_FFFF_FFFF) ? '1 : sum[47:0];
        endfunction

        function void note_tick(logic [79:0] t);
            logic [31:0]  now;
            logic [31:0]  elapsed;
            int           top;
            int           bottom;
            int           hum;
            int           goal;
            int           band;
            int           load;
            tick_result_t r;
            now = t[31:0];
            top = int'($signed(t[46:32]));
            bottom = int'($signed(t[61:47]));
            hum = int'(t[75:62]);
            r.drive = '0;
            load = 0;
            if (regs.enable) begin
                if (fresh) begin
                    flush_stamp = now;
                    fresh = 1'b0;
                end
                elapsed = now - flush_stamp;
                if ((load_last != 0 && elapsed > FLUSH_MS) || load_prior != load_last) begin
                    lifetime_sm = sat_add(lifetime_sm, 64'(elapsed) * 64'(load_prior));
                    session_sm = sat_add(session_sm, 64'(elapsed) * 64'(load_prior));
                    flush_stamp = now;
                end
                if (top - bottom > int'(regs.fan_delta) * 100)
                    r.drive.fan_on = regs.fan_request;
                // Bio mode heats toward the complement of the humidity target.
                if (regs.run_mode == shsc_pkg::MODE_BIO)
                    goal = (100 - int'(regs.target_humidity)) * 100;
                else
                    goal = int'(regs.target_temp) * 100;
                if (regs.run_mode == shsc_pkg::MODE_BIO
                    || regs.run_mode == shsc_pkg::MODE_CUSTOM) begin
                    if (hum <= int'(regs.target_humidity) * 100) begin
                        r.drive.steam_on = 1'b1;
                        load += 1;
                    end
                end
                band = int'(regs.temp_band);
                if (top > goal)
                    r.drive.heat_stages = 2'd0;
                else if (top > goal - band * 100 && goal - top < (band / 3) * 100)
                    r.drive.heat_stages = 2'd2;
                else
                    r.drive.heat_stages = 2'd3;
                load += int'(r.drive.heat_stages);
                load_prior = load_last;
                load_last = load[2:0];
            end
            else begin
                if (!fresh && load_last != 0) begin
                    elapsed = now - flush_stamp;
                    lifetime_sm = sat_add(lifetime_sm, 64'(elapsed) * 64'(load_last));
                end
                fresh = 1'b1;
                session_sm = '0;
                load_last = '0;
                flush_stamp = '0;
            end
            r.total = lifetime_sm;
            r.session = session_sm;
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [103:0] d);
            tick_result_t want;
            if (pending_q.size() == 0) begin
                $error("result arrived with no tick outstanding");
                fail_count++;
                return;
            end
            want = pending_q.pop_front();
            if (d[1:0] !== want.drive.heat_stages) begin
                $error("heat_stages: expected %0d, got %0d", want.drive.heat_stages, d[1:0]);
                fail_count++;
            end
            if (d[2] !== want.drive.steam_on) begin
                $error("steam_on: expected %0d, got %0d", want.drive.steam_on, d[2]);
                fail_count++;
            end
            if (d[3] !== want.drive.fan_on) begin
                $error("fan_on: expected %0d, got %0d", want.drive.fan_on, d[3]);
                fail_count++;
            end
            if (d[51:4] !== want.total) begin
                $error("total_energy: expected %0d, got %0d", want.total, d[51:4]);
                fail_count++;
            end
            if (d[99:52] !== want.session) begin
                $error("session_energy: expected %0d, got %0d", want.session, d[99:52]);
                fail_count++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [79:0]   s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [103:0]  m_axis_tdata;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [2:0]    cfg_index;
    logic [6:0]    cfg_data;

    heater_scoreboard sb;
    logic [31:0] clock_ms;
    bit          s_steady;
    bit          m_steady;
    int          idle_cycles = 0;

    staged_heater_steam_controller #(
        .FLUSH_INTERVAL_MS(FLUSH_MS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Any channel moving a transaction counts as progress.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic program_regs(input logic en, input logic [1:0] mode, input logic [6:0] tt,
                                input logic [6:0] th, input logic [6:0] band,
                                input logic [6:0] delta, input logic fan_req);
        cfg_write(shsc_pkg::REG_ENABLE, {6'd0, en});
        cfg_write(shsc_pkg::REG_RUN_MODE, {5'd0, mode});
        cfg_write(shsc_pkg::REG_TARGET_TEMP, tt);
        cfg_write(shsc_pkg::REG_TARGET_HUMIDITY, th);
        cfg_write(shsc_pkg::REG_TEMP_BAND, band);
        cfg_write(shsc_pkg::REG_FAN_DELTA, delta);
        cfg_write(shsc_pkg::REG_FAN_REQUEST, {6'd0, fan_req});
        cfg_valid <= 1'b0;
    endtask

    // Holds off the sender until every outstanding result has been checked.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_tick(input logic [31:0] now, input int top, input int bottom,
                             input int hum);
        logic [79:0] d;
        int          gap;
        d = {4'd0, hum[13:0], bottom[14:0], top[14:0], now};
        gap = s_steady ? 0 : int'($urandom_range(0, 5));
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_tick(d);
    endtask

    function automatic logic [6:0] pick_reg(input int span);
        case ($urandom_range(0, 5))
            0: return 7'd0;
            1: return span[6:0];
            2: return 7'd127;
            3: return 7'($urandom_range(0, 127));
            default: return 7'($urandom_range(0, span));
        endcase
    endfunction

    task automatic send_random_tick;
        int center;
        int band;
        int top;
        int bottom;
        int hum;
        band = int'(sb.regs.temp_band);
        if (sb.regs.run_mode == shsc_pkg::MODE_BIO)
            center = (100 - int'(sb.regs.target_humidity)) * 100;
        else
            center = int'(sb.regs.target_temp) * 100;
        case ($urandom_range(0, 19)) inside
            [0:11]: clock_ms = clock_ms + $urandom_range(0, 2500);
            [12:15]: clock_ms = clock_ms + $urandom_range(5000, 15000);
            16: ;
            17: clock_ms = clock_ms - $urandom_range(0, 3000);
            18: clock_ms = $urandom();
            default: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        endcase
        case ($urandom_range(0, 19)) inside
            [0:12]: top = center + 400 - int'($urandom_range(0, band * 100 + 800));
            [13:15]: top = int'($urandom_range(0, 16000)) - 4000;
            default: top = int'($urandom_range(0, 32767)) - 16384;
        endcase
        if ($urandom_range(0, 9) < 6)
            bottom = top - int'(sb.regs.fan_delta) * 100 + int'($urandom_range(0, 600)) - 300;
        else
            bottom = int'($urandom_range(0, 32767)) - 16384;
        if ($urandom_range(0, 9) < 6) begin
            hum = int'(sb.regs.target_humidity) * 100 + int'($urandom_range(0, 600)) - 300;
            if (hum < 0)
                hum = 0;
        end
        else
            hum = int'($urandom_range(0, 16383));
        send_tick(clock_ms, top, bottom, hum);
    endtask

    initial
    begin
        @(posedge rst_n);
        forever begin
            int stall;
            stall = m_steady ? 0 : int'($urandom_range(0, 5));
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            sb.check_result(m_axis_tdata);
        end
    end

    initial
    begin
        int random_ticks;
        int phase_len;
        sb = new();
        s_steady = 1'b0;
        m_steady = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        clock_ms = 32'd0;
        random_ticks = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset the block is disabled and starts fresh.
        send_tick(32'd100, 2000, 1000, 5000);
        drain();

        // Dry heat: every staging case, fan edge and a timestamp wrap.
        program_regs(1'b1, shsc_pkg::MODE_DRY, 7'd80, 7'd50, 7'd20, 7'd10, 1'b1);
        send_tick(32'd1000, 8100, 0, 0);
        send_tick(32'd1500, 7000, 0, 0);
        send_tick(32'd2500, 7500, 0, 0);
        send_tick(32'd3000, 8000, 7000, 0);
        send_tick(32'd4000, -4000, 12000, 10000);
        send_tick(32'd20000, 7000, 0, 0);
        send_tick(32'hFFFF_F000, 12000, -4000, 0);
        send_tick(32'h0000_1000, 6000, 0, 0);
        drain();

        // Bio mode with a humidity target past 100 gives a negative temperature goal.
        program_regs(1'b1, shsc_pkg::MODE_BIO, 7'd80, 7'd127, 7'd0, 7'd10, 1'b0);
        send_tick(32'd5000, -2800, -4000, 10000);
        send_tick(32'd6000, -2600, -4000, 16383);
        send_tick(32'd7000, -2700, 12000, 12700);
        drain();

        program_regs(1'b1, shsc_pkg::MODE_CUSTOM, 7'd127, 7'd0, 7'd127, 7'd0, 1'b1);
        send_tick(32'd8000, 12000, 11999, 0);
        send_tick(32'd9000, 16383, -16384, 1);
        send_tick(32'd30000, -16384, 16383, 0);
        send_tick(32'd31000, 500, 500, 0);
        drain();

        // The fourth mode code runs as dry heat.
        program_regs(1'b1, MODE_UNUSED, 7'd0, 7'd100, 7'd127, 7'd120, 1'b1);
        send_tick(32'd40000, 0, 0, 0);
        send_tick(32'd41000, 1, 0, 0);
        drain();

        // Switching off after a tick with no load running books no open interval.
        program_regs(1'b0, MODE_UNUSED, 7'd0, 7'd100, 7'd127, 7'd120, 1'b1);
        send_tick(32'd45000, 0, 0, 0);
        send_tick(32'd46000, 0, 0, 0);
        drain();

        while (random_ticks < RANDOM_TICKS) begin
            program_regs($urandom_range(0, 99) < 85, 2'($urandom_range(0, 3)), pick_reg(120),
                         pick_reg(100), pick_reg(120), pick_reg(120),
                         1'($urandom_range(0, 1)));
            s_steady = ($urandom_range(0, 3) == 0);
            m_steady = ($urandom_range(0, 3) == 0);
            phase_len = int'($urandom_range(10, 60));
            repeat (phase_len) begin
                send_random_tick();
                random_ticks++;
            end
            drain();
        end

        // Full load with a near-wrap interval every tick grows both totals in
        // large steps; the lifetime total must carry across a disable.
        s_steady = 1'b1;
        m_steady = 1'b1;
        program_regs(1'b1, shsc_pkg::MODE_CUSTOM, 7'd127, 7'd127, 7'd0, 7'd0, 1'b1);
        repeat (WRAP_TICKS) begin
            clock_ms = clock_ms - 32'd1;
            send_tick(clock_ms, 0, 0, 0);
        end
        drain();
        program_regs(1'b0, shsc_pkg::MODE_CUSTOM, 7'd127, 7'd127, 7'd0, 7'd0, 1'b1);
        send_tick(clock_ms + 32'd500, 0, 0, 0);
        drain();
        program_regs(1'b1, shsc_pkg::MODE_CUSTOM, 7'd127, 7'd127, 7'd0, 7'd0, 1'b1);
        repeat (5) begin
            clock_ms = clock_ms + 32'd20000;
            send_tick(clock_ms, 0, 0, 0);
        end
        drain();
        repeat (8) @(posedge clk);

        if (sb.fail_count == 0 && sb.pending_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
